// ===== rtl/pica_pkg.sv =====
// pica_pkg: shared types and constants of the pi controller with anti-windup
// used by the drive channel interface and by the top level pi_controller_antiwindup
// no dependencies
package pica_pkg;

  // fixed widths of the gain registers and of the integrator
  localparam int GAIN_W  = 16;
  localparam int INTEG_W = 32;

  // configuration register index width and register indexes
  localparam int REG_IDX_W = 8;
  localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN  = 8'd0;
  localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN = 8'd1;
  localparam logic [REG_IDX_W-1:0] REG_OUT_UPPER  = 8'd2;
  localparam logic [REG_IDX_W-1:0] REG_OUT_LOWER  = 8'd3;

  // clamp status reported with every drive value
  typedef enum logic [1:0] {
    CLAMP_NONE  = 2'd0,
    CLAMP_UPPER = 2'd1,
    CLAMP_LOWER = 2'd2
  } clamp_t;

endpackage

// ===== rtl/pica_sample_if.sv =====
// pica_sample_if: valid/ready channel that carries one controller sample
// depends on nothing; sample width is a parameter
interface pica_sample_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] setpoint;
  logic signed [SAMPLE_WIDTH-1:0] measured;

  modport source (output valid, output setpoint, output measured, input ready);
  modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

// ===== rtl/pica_drive_if.sv =====
// pica_drive_if: valid/ready channel that carries one controller result
// depends on pica_pkg for the clamp status type
interface pica_drive_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] drive;
  pica_pkg::clamp_t               clamp_state;

  modport source (output valid, output drive, output clamp_state, input ready);
  modport sink   (input valid, input drive, input clamp_state, output ready);
endinterface

// ===== rtl/pi_controller_antiwindup.sv =====
// pi_controller_antiwindup: pi controller with integrator clamp anti-windup
// a sample transaction passes through the input register, then the product register,
// then the result register; throughput one sample per cycle while the result is not held
// the stages stall together only as far as the held result requires
// synchronous active-high reset clears the integrator, pipeline valids and gains and
// sets the limits to the full signed range; depends on pica_pkg and both interfaces
module pi_controller_antiwindup #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int FRAC_BITS    = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [pica_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [((SAMPLE_WIDTH > pica_pkg::GAIN_W) ? SAMPLE_WIDTH
                                                   : pica_pkg::GAIN_W)-1:0] cfg_data,
  pica_sample_if.sink                          sample,
  pica_drive_if.source                         result
);
  import pica_pkg::*;

  localparam int SW     = SAMPLE_WIDTH;
  localparam int ERR_W  = SW + 1;
  localparam int PROD_W = ERR_W + GAIN_W + 1;
  localparam int LIM_W  = SW + FRAC_BITS;
  localparam int MAX_A  = (PROD_W > INTEG_W) ? PROD_W : INTEG_W;
  localparam int MAX_B  = (MAX_A > LIM_W) ? MAX_A : LIM_W;
  localparam int ACC_W  = MAX_B + 2;

  // saturate a wide signed value to the integrator range
  function automatic logic signed [INTEG_W-1:0] sat_integ(input logic signed [ACC_W-1:0] v);
    logic upper_ones;
    logic upper_zeros;
    upper_ones  = &v[ACC_W-1:INTEG_W-1];
    upper_zeros = ~|v[ACC_W-1:INTEG_W-1];
    if (upper_ones || upper_zeros) begin
      sat_integ = v[INTEG_W-1:0];
    end else if (v[ACC_W-1]) begin
      sat_integ = {1'b1, {(INTEG_W-1){1'b0}}};
    end else begin
      sat_integ = {1'b0, {(INTEG_W-1){1'b1}}};
    end
  endfunction

  // configuration registers
  logic        [GAIN_W-1:0] prop_gain;
  logic        [GAIN_W-1:0] integ_gain;
  logic signed [SW-1:0]     out_upper;
  logic signed [SW-1:0]     out_lower;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= '0;
      integ_gain <= '0;
      out_upper  <= {1'b0, {(SW-1){1'b1}}};
      out_lower  <= {1'b1, {(SW-1){1'b0}}};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROP_GAIN:  prop_gain  <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN: integ_gain <= cfg_data[GAIN_W-1:0];
        REG_OUT_UPPER:  out_upper  <= cfg_data[SW-1:0];
        REG_OUT_LOWER:  out_lower  <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  // stage enables: each stage moves when its successor has room
  logic in_valid;
  logic prod_valid;
  logic out_valid;
  logic out_load;
  logic prod_load;
  logic in_load;

  assign out_load  = !out_valid || result.ready;
  assign prod_load = !prod_valid || out_load;
  assign in_load   = !in_valid || prod_load;
  assign sample.ready = in_load;

  // input register
  logic signed [SW-1:0] setpoint_q;
  logic signed [SW-1:0] measured_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_load) begin
      in_valid <= sample.valid;
    end
    if (in_load && sample.valid) begin
      setpoint_q <= sample.setpoint;
      measured_q <= sample.measured;
    end
  end

  // error and both gain products
  logic signed [ERR_W-1:0]    err;
  logic signed [GAIN_W:0]     prop_s;
  logic signed [GAIN_W:0]     integ_s;
  logic signed [PROD_W-1:0]   p_prod_next;
  logic signed [PROD_W-1:0]   i_prod_next;
  logic signed [PROD_W-1:0]   p_prod;
  logic signed [PROD_W-1:0]   i_prod;

  always_comb begin
    err         = ERR_W'(setpoint_q) - ERR_W'(measured_q);
    prop_s      = {1'b0, prop_gain};
    integ_s     = {1'b0, integ_gain};
    p_prod_next = prop_s * err;
    i_prod_next = integ_s * err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_load) begin
      prod_valid <= in_valid;
    end
    if (prod_load && in_valid) begin
      p_prod <= p_prod_next;
      i_prod <= i_prod_next;
    end
  end

  // integrator update, limit test and back-calculation
  logic signed [INTEG_W-1:0] integ;
  logic signed [INTEG_W-1:0] integ_acc;
  logic signed [INTEG_W-1:0] integ_next;
  logic signed [ACC_W-1:0]   sum;
  logic signed [ACC_W-1:0]   p_wide;
  logic signed [ACC_W-1:0]   hi_q;
  logic signed [ACC_W-1:0]   lo_q;
  logic signed [ACC_W-1:0]   floor_val;
  logic signed [SW-1:0]      drive_next;
  clamp_t                    clamp_next;

  always_comb begin
    p_wide     = ACC_W'(p_prod);
    hi_q       = ACC_W'(out_upper) <<< FRAC_BITS;
    lo_q       = ACC_W'(out_lower) <<< FRAC_BITS;
    integ_acc  = sat_integ(ACC_W'(integ) + ACC_W'(i_prod));
    sum        = p_wide + ACC_W'(integ_acc);
    floor_val  = sum >>> FRAC_BITS;
    integ_next = integ_acc;
    drive_next = floor_val[SW-1:0];
    clamp_next = CLAMP_NONE;
    if (sum > hi_q) begin
      integ_next = (p_wide > hi_q) ? '0 : sat_integ(hi_q - p_wide);
      drive_next = out_upper;
      clamp_next = CLAMP_UPPER;
    end else if (sum < lo_q) begin
      integ_next = (p_wide < lo_q) ? '0 : sat_integ(lo_q - p_wide);
      drive_next = out_lower;
      clamp_next = CLAMP_LOWER;
    end
  end

  // integrator state and result register
  logic signed [SW-1:0] drive_q;
  clamp_t               clamp_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      integ     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= prod_valid;
      end
      if (out_load && prod_valid) begin
        integ <= integ_next;
      end
    end
    if (out_load && prod_valid) begin
      drive_q <= drive_next;
      clamp_q <= clamp_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.drive       = drive_q;
  assign result.clamp_state = clamp_q;

  // integrator comes out of reset cleared
  a_integ_reset: assert property (@(posedge clk) rst |=> integ == '0)
    else $error("integrator not cleared by reset");

  // a held result freezes the integrator
  a_integ_hold: assert property (@(posedge clk) disable iff (rst)
    !out_load |=> $stable(integ))
    else $error("integrator changed while result stalled");

  // a sample leaving the product stage shows up as a result
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    prod_valid && out_load |=> result.valid)
    else $error("result lost between product stage and output");

endmodule
